// ===== rtl/hssc_pkg.sv =====
package hssc_pkg;

    localparam int CHANNEL_COUNT_DEF = 43;

    localparam int CHAN_W = 6;
    localparam int FREQ_W = 22;
    localparam int CNT_W = 32;
    localparam int TIME_W = 32;
    localparam int PERIOD_W = 20;
    localparam int MODE_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 96;
    localparam int IN_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TIME = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

    localparam logic ACT_TX = 1'b0;
    localparam logic ACT_HOP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_END = 2'd3;

    localparam logic [31:0] SEED_RST = 32'h6D4C5253;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd52631;
    localparam logic [FREQ_W-1:0] BAND_START_RST = 22'd902000;
    localparam logic [FREQ_W-1:0] BAND_END_RST = 22'd928000;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    typedef struct packed {
        logic in_load;
        logic init_start;
        logic init_step;
        logic wr_init;
        logic lcg_step;
        logic div_start;
        logic freq_calc;
        logic lat_j;
        logic rd_i;
        logic rd_j;
        logic wr_i;
        logic wr_j;
        logic i_dec;
        logic start_apply;
        logic stop;
        logic slot_apply;
        logic rd_pos;
        logic num_calc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic running;
        logic due;
        logic init_last;
        logic sh_last;
        logic div_busy;
        logic div_done;
        logic out_busy;
    } t_status;

endpackage

// ===== rtl/hop_sequence_slot_controller.sv =====
// Frequency hop slot controller. A start item (tuser 0) shuffles the channel table with a
// seeded congruential generator and a Fisher-Yates pass, then emits a transmit on the first
// channel; time items (tuser 1) past one frame period alternate transmit and hop results;
// a stop item (tuser 2) halts. One item is worked at a time. A time item passes through the
// accept, decode, table read, grid numerator, reciprocal multiply for the division by N-1,
// and the output load steps. A start item first fills the table with the N channels in order,
// then every shuffle step runs a serial divider for its modulo and then four accesses on the
// channel table. A finished result waits in the output register while the next item is taken.
module hop_sequence_slot_controller #(
    parameter int CHANNEL_COUNT = hssc_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hssc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hssc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // now_us [31:0]
    input  logic [hssc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode [1:0]
    input  logic [hssc_pkg::MODE_W-1:0]     s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // channel_number [5:0], frequency_khz [27:6], frames_sent [59:28],
    // hops_made [91:60], zero [95:92]
    output logic [hssc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // action [0]
    output logic                            m_axis_tuser
);

    hssc_pkg::t_cmd    w_cmd;
    hssc_pkg::t_status w_st;

    hssc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    hssc_dp #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_data    (s_axis_tdata),
        .i_in_mode    (s_axis_tuser),
        .i_cmd        (w_cmd),
        .o_st         (w_st),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_action (m_axis_tuser)
    );

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_st.div_busy)
        else $error("divider started while busy");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !w_st.out_busy)
        else $error("result loaded over a pending one");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.wr_init, w_cmd.wr_i, w_cmd.wr_j}))
        else $error("two table writes in one cycle");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st.div_busy |-> !s_axis_tready)
        else $error("item taken while divider runs");

endmodule

// ===== rtl/hssc_div.sv =====
module hssc_div #(
    parameter int DIV_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DIV_W-1:0] o_remainder
);

    logic [31:0]      r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   w_trial;
    logic             w_fit;

    // Restoring division, one quotient bit per cycle.
    assign w_trial = {r_rem, r_quo[31]};
    assign w_fit = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_quo <= i_dividend;
                r_rem <= '0;
                r_den <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[30:0], w_fit};
                r_rem <= w_fit ? DIV_W'(w_trial - {1'b0, r_den}) : DIV_W'(w_trial);
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/hssc_ctrl.sv =====
module hssc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hssc_pkg::t_status i_st,
    output hssc_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_INIT, ST_LCG, ST_SDIV, ST_SWAIT, ST_RDI, ST_RDJ,
        ST_WRI, ST_WRJ, ST_RD, ST_NUM, ST_FREQ, ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (i_st.mode == hssc_pkg::MODE_START) begin
                    o_cmd.init_start = 1'b1;
                    n_state = ST_INIT;
                end else if (i_st.mode == hssc_pkg::MODE_STOP) begin
                    o_cmd.stop = 1'b1;
                    n_state = ST_IDLE;
                end else if (i_st.mode == hssc_pkg::MODE_TIME && i_st.running
                             && i_st.due) begin
                    o_cmd.slot_apply = 1'b1;
                    n_state = ST_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_INIT: begin
                o_cmd.wr_init = 1'b1;
                if (i_st.init_last) begin
                    n_state = ST_LCG;
                end else begin
                    o_cmd.init_step = 1'b1;
                end
            end
            ST_LCG: begin
                o_cmd.lcg_step = 1'b1;
                n_state = ST_SDIV;
            end
            ST_SDIV: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (i_st.div_done) begin
                    o_cmd.lat_j = 1'b1;
                    n_state = ST_RDI;
                end
            end
            ST_RDI: begin
                o_cmd.rd_i = 1'b1;
                n_state = ST_RDJ;
            end
            ST_RDJ: begin
                o_cmd.rd_j = 1'b1;
                n_state = ST_WRI;
            end
            ST_WRI: begin
                o_cmd.wr_i = 1'b1;
                n_state = ST_WRJ;
            end
            ST_WRJ: begin
                o_cmd.wr_j = 1'b1;
                if (i_st.sh_last) begin
                    o_cmd.start_apply = 1'b1;
                    n_state = ST_RD;
                end else begin
                    o_cmd.i_dec = 1'b1;
                    n_state = ST_LCG;
                end
            end
            ST_RD: begin
                o_cmd.rd_pos = 1'b1;
                n_state = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.num_calc = 1'b1;
                n_state = ST_FREQ;
            end
            ST_FREQ: begin
                o_cmd.freq_calc = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_st.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ===== rtl/hssc_dp.sv =====
module hssc_dp #(
    parameter int CHANNEL_COUNT = hssc_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hssc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hssc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [hssc_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic [hssc_pkg::MODE_W-1:0]      i_in_mode,
    input  hssc_pkg::t_cmd                   i_cmd,
    output hssc_pkg::t_status                o_st,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [hssc_pkg::OUT_DATA_W-1:0]  o_out_data,
    output logic                             o_out_action
);

    localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int DIV_W = $clog2(CHANNEL_COUNT + 1);
    localparam int CW = hssc_pkg::CHAN_W;
    localparam int FW = hssc_pkg::FREQ_W;
    localparam int NW = CW + FW + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNEL_COUNT - 1);
    // Rounded-up reciprocal of N-1; exact for every numerator below 2^NW.
    localparam int SH = NW + $clog2(CHANNEL_COUNT - 1);
    localparam int PW = 2 * NW + 1;
    localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(CHANNEL_COUNT - 2)) / 64'(CHANNEL_COUNT - 1);

    // Configuration registers.
    logic [31:0]                   r_seed;
    logic [hssc_pkg::PERIOD_W-1:0] r_period;
    logic [FW-1:0]                 r_band_start;
    logic [FW-1:0]                 r_band_end;

    // Item and slot state.
    logic [hssc_pkg::MODE_W-1:0] r_mode;
    logic [31:0]                 r_now;
    logic                        r_run;
    logic                        r_tx;
    logic [IDX_W-1:0]            r_pos;
    logic [31:0]                 r_last;
    logic [31:0]                 r_frames;
    logic [31:0]                 r_hops;
    logic                        r_action;

    // Shuffle state.
    logic [31:0]      r_x;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [CW-1:0]    r_ti;
    logic [CW-1:0]    r_rdata;
    logic [CW-1:0]    mem [CHANNEL_COUNT];
    logic [IDX_W-1:0] w_rd_addr;

    // Frequency path and output register.
    logic [CW-1:0]  r_chan;
    logic [NW-1:0]  r_num;
    logic [FW-1:0]  r_freq;
    logic [CW-1:0]  w_cw;
    logic [NW-1:0]  w_num;
    logic [PW-1:0]  w_prod;
    logic           r_out_valid;
    logic [CW-1:0]  r_out_chan;
    logic [FW-1:0]  r_out_freq;
    logic [31:0]    r_out_frames;
    logic [31:0]    r_out_hops;
    logic           r_out_action;

    logic [31:0]      w_div_dividend;
    logic [DIV_W-1:0] w_div_divisor;
    logic             w_div_busy;
    logic             w_div_done;
    logic [DIV_W-1:0] w_div_rem;
    logic [31:0]      w_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= hssc_pkg::SEED_RST;
            r_period <= hssc_pkg::PERIOD_RST;
            r_band_start <= hssc_pkg::BAND_START_RST;
            r_band_end <= hssc_pkg::BAND_END_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hssc_pkg::REG_SEED:       r_seed <= i_cfg_data;
                hssc_pkg::REG_PERIOD:     r_period <= i_cfg_data[hssc_pkg::PERIOD_W-1:0];
                hssc_pkg::REG_BAND_START: r_band_start <= i_cfg_data[FW-1:0];
                hssc_pkg::REG_BAND_END:   r_band_end <= i_cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    assign w_elapsed = r_now - r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_mode <= i_in_mode;
            r_now <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_tx <= 1'b1;
            r_pos <= '0;
            r_last <= '0;
            r_frames <= '0;
            r_hops <= '0;
            r_action <= hssc_pkg::ACT_TX;
        end else begin
            if (i_cmd.stop) begin
                r_run <= 1'b0;
            end
            if (i_cmd.start_apply) begin
                r_run <= 1'b1;
                r_tx <= 1'b1;
                r_pos <= '0;
                r_last <= r_now;
                r_frames <= 32'd1;
                r_hops <= '0;
                r_action <= hssc_pkg::ACT_TX;
            end
            if (i_cmd.slot_apply) begin
                r_last <= r_last + 32'(r_period);
                if (r_tx) begin
                    r_tx <= 1'b0;
                    r_frames <= r_frames + 32'd1;
                    r_action <= hssc_pkg::ACT_TX;
                end else begin
                    r_tx <= 1'b1;
                    r_pos <= (r_pos == LAST_IDX) ? '0 : r_pos + IDX_W'(1);
                    r_hops <= r_hops + 32'd1;
                    r_action <= hssc_pkg::ACT_HOP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_start) begin
            r_i <= '0;
            r_x <= r_seed;
        end else if (i_cmd.init_step) begin
            r_i <= r_i + IDX_W'(1);
        end else if (i_cmd.i_dec) begin
            r_i <= r_i - IDX_W'(1);
        end
        if (i_cmd.lcg_step) begin
            r_x <= 32'(r_x * hssc_pkg::LCG_MUL) + hssc_pkg::LCG_ADD;
        end
        if (i_cmd.lat_j) begin
            r_j <= IDX_W'(w_div_rem);
        end
        if (i_cmd.rd_j) begin
            r_ti <= r_rdata;
        end
    end

    // Channel table: one write and one registered read per cycle.
    always_comb begin
        priority if (i_cmd.rd_j) begin
            w_rd_addr = r_j;
        end else if (i_cmd.rd_pos) begin
            w_rd_addr = r_pos;
        end else begin
            w_rd_addr = r_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[w_rd_addr];
        priority if (i_cmd.wr_init) begin
            mem[r_i] <= CW'(r_i);
        end else if (i_cmd.wr_i) begin
            mem[r_i] <= r_rdata;
        end else if (i_cmd.wr_j) begin
            mem[r_j] <= r_ti;
        end
    end

    // Grid numerator (N-1-c)*start + c*end; it is divided by N-1 afterward.
    assign w_cw = CW'(CHANNEL_COUNT - 1) - r_rdata;
    assign w_num = NW'(w_cw) * NW'(r_band_start) + NW'(r_rdata) * NW'(r_band_end);
    assign w_prod = PW'(r_num) * PW'(RECIP[NW:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.num_calc) begin
            r_chan <= r_rdata;
            r_num <= w_num;
        end
        if (i_cmd.freq_calc) begin
            r_freq <= w_prod[SH +: FW];
        end
    end

    assign w_div_dividend = r_x;
    assign w_div_divisor = DIV_W'(r_i) + DIV_W'(1);

    hssc_div #(
        .DIV_W(DIV_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (w_div_divisor),
        .o_busy      (w_div_busy),
        .o_done      (w_div_done),
        .o_remainder (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_chan <= r_chan;
            r_out_freq <= r_freq;
            r_out_frames <= r_frames;
            r_out_hops <= r_hops;
            r_out_action <= r_action;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_action = r_out_action;
    assign o_out_data = {4'b0, r_out_hops, r_out_frames, r_out_freq, r_out_chan};

    assign o_st.mode = r_mode;
    assign o_st.running = r_run;
    assign o_st.due = (w_elapsed >= 32'(r_period));
    assign o_st.init_last = (r_i == LAST_IDX);
    assign o_st.sh_last = (r_i == IDX_W'(1));
    assign o_st.div_busy = w_div_busy;
    assign o_st.div_done = w_div_done;
    assign o_st.out_busy = r_out_valid && !i_out_ready;

endmodule
